/* src/lcvs_pkg.sv */
// Shared constants, types and helpers for the LED cube voxel store and scanner.
// Depends on nothing; every other file imports it.
package lcvs_pkg;

	localparam int CUBE_SIDE   = 24;
	localparam int CUBE_LAYERS = 32;
	localparam int TILE_SIDE   = 8;

	localparam int LANES     = 9;
	localparam int LANE_W    = $clog2(LANES);
	localparam int LAYER_W   = (CUBE_LAYERS > 1) ? $clog2(CUBE_LAYERS) : 1;
	localparam int TILE_W    = $clog2(TILE_SIDE * TILE_SIDE);
	localparam int ADDR_W    = LAYER_W + TILE_W;
	localparam int MEM_DEPTH = CUBE_LAYERS * TILE_SIDE * TILE_SIDE;

	localparam logic [ADDR_W-1:0]  CLR_LAST   = ADDR_W'(MEM_DEPTH - 1);
	localparam logic [LAYER_W-1:0] LAYER_LAST = LAYER_W'(CUBE_LAYERS - 1);
	localparam logic [5:0]         SIDE_LIM   = 6'(CUBE_SIDE);
	localparam logic [5:0]         LAYER_LIM  = 6'(CUBE_LAYERS);
	localparam logic [7:0]         LATCH_STEP = 8'(3 * TILE_SIDE * TILE_SIDE);

	localparam logic [7:0] CMD_CLEAR = 8'hE1;
	localparam int         START_BIT = 7;
	localparam int         RGB_BIT   = 6;

	localparam logic [1:0] COLOR_RED   = 2'd0;
	localparam logic [1:0] COLOR_GREEN = 2'd1;
	localparam logic [1:0] COLOR_BLUE  = 2'd2;

	typedef struct packed {
		logic take_byte;
		logic take_tick;
		logic load_out;
		logic clear_step;
	} lcvs_cmd_t;

	typedef struct packed {
		logic clear_req;
		logic clear_done;
	} lcvs_sts_t;

	// scan order within a layer: green, blue, red
	function automatic logic [1:0] color_of_slot(input logic [1:0] slot);
		logic [1:0] c;
		unique case (slot)
			2'd0: c = COLOR_GREEN;
			2'd1: c = COLOR_BLUE;
			2'd2: c = COLOR_RED;
			default: c = COLOR_RED;
		endcase
		return c;
	endfunction

endpackage

/* src/lcvs_ifs.sv */
// Valid/ready channel interfaces for the input beats and the result beats.
// Depends on lcvs_pkg.
interface lcvs_in_if import lcvs_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] rx_byte;

	modport source (output valid, output func, output rx_byte, input ready);
	modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface lcvs_out_if import lcvs_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [8:0] lane_bits;
	logic       shift_pulse;
	logic       latch_pulse;
	logic [4:0] layer_index;
	logic [1:0] color_index;

	modport source (output valid, output lane_bits, output shift_pulse, output latch_pulse,
		output layer_index, output color_index, input ready);
	modport sink   (input valid, input lane_bits, input shift_pulse, input latch_pulse,
		input layer_index, input color_index, output ready);
endinterface

/* src/lcvs_ctrl.sv */
// Controller: handshakes, store clearing sequence and result valid.
// Depends on lcvs_pkg.
module lcvs_ctrl import lcvs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_func,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  lcvs_sts_t sts,
	output lcvs_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_CLEAR = 3'b010,
		ST_READ  = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.take_byte  = accept && !in_func;
		cmd.take_tick  = accept && in_func;
		cmd.load_out   = (state_q == ST_READ) && out_free;
		cmd.clear_step = (state_q == ST_CLEAR);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.take_byte && sts.clear_req) state_d = ST_CLEAR;
				else if (cmd.take_tick) state_d = ST_READ;
			end
			ST_CLEAR: begin
				if (sts.clear_done) state_d = ST_IDLE;
			end
			ST_READ: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

/* src/lcvs_dpath.sv */
// Datapath: byte parser, nine lane banks of voxel memory, scan counters and result register.
// Depends on lcvs_pkg.
module lcvs_dpath import lcvs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  lcvs_cmd_t  cmd,
	output lcvs_sts_t  sts,
	input  logic [7:0] rx_byte,
	output logic [8:0] lane_bits,
	output logic       shift_pulse,
	output logic       latch_pulse,
	output logic [4:0] layer_index,
	output logic [1:0] color_index
);

	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_X_HELD = 2'd1,
		PH_Y_HELD = 2'd2
	} phase_t;

	phase_t             phase_q;
	logic [4:0]         pend_x_q;
	logic [4:0]         pend_y_q;
	logic [1:0]         pend_rg_q;
	logic [7:0]         step_q;
	logic [LAYER_W-1:0] layer_q;
	logic [ADDR_W-1:0]  clr_addr_q;

	logic [2:0]        rd_q [LANES];
	logic              vox_we;
	logic [LANE_W-1:0] wr_lane;
	logic [ADDR_W-1:0] mem_waddr;
	logic [2:0]        mem_wdata;
	logic [ADDR_W-1:0] rd_addr;
	logic              is_latch;
	logic [1:0]        color;
	logic [8:0]        lanes;

	assign sts.clear_req  = (phase_q == PH_FIRST) && (rx_byte == CMD_CLEAR);
	assign sts.clear_done = (clr_addr_q == CLR_LAST);

	assign vox_we = cmd.take_byte && (phase_q == PH_Y_HELD)
		&& ({1'b0, pend_x_q} < SIDE_LIM) && ({1'b0, pend_y_q} < SIDE_LIM)
		&& ({1'b0, rx_byte[4:0]} < LAYER_LIM);
	// lane = x/8 + 3*(y/8)
	assign wr_lane = LANE_W'({2'b00, pend_x_q[4:3]} + {1'b0, pend_y_q[4:3], 1'b0}
		+ {2'b00, pend_y_q[4:3]});
	assign mem_waddr = cmd.clear_step ? clr_addr_q
		: {rx_byte[LAYER_W-1:0], pend_y_q[2:0], pend_x_q[2:0]};
	assign mem_wdata = cmd.clear_step ? 3'b000 : {rx_byte[RGB_BIT], pend_rg_q};
	assign rd_addr   = {layer_q, step_q[TILE_W-1:0]};

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic [2:0] mem [MEM_DEPTH];
		always_ff @(posedge clk) begin
			if (cmd.clear_step || (vox_we && wr_lane == LANE_W'(l))) begin
				mem[mem_waddr] <= mem_wdata;
			end
			if (cmd.take_tick) begin
				rd_q[l] <= mem[rd_addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear_step) begin
			clr_addr_q <= sts.clear_done ? '0 : clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_FIRST;
			pend_x_q  <= '0;
			pend_y_q  <= '0;
			pend_rg_q <= '0;
		end else if (cmd.take_byte) begin
			unique case (phase_q)
				PH_X_HELD: begin
					pend_y_q     <= rx_byte[4:0];
					pend_rg_q[1] <= rx_byte[RGB_BIT];
					phase_q      <= PH_Y_HELD;
				end
				PH_Y_HELD: phase_q <= PH_FIRST;
				default: begin
					if (rx_byte != CMD_CLEAR && rx_byte[START_BIT]) begin
						pend_x_q  <= rx_byte[4:0];
						pend_rg_q <= {1'b0, rx_byte[RGB_BIT]};
						phase_q   <= PH_X_HELD;
					end
				end
			endcase
		end
	end

	assign is_latch = (step_q == LATCH_STEP);
	assign color    = color_of_slot(step_q[7:6]);

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			lanes[l] = rd_q[l][color];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			layer_q <= '0;
		end else if (cmd.load_out) begin
			if (is_latch) begin
				step_q  <= '0;
				layer_q <= (layer_q == LAYER_LAST) ? '0 : layer_q + 1'b1;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			lane_bits   <= is_latch ? 9'd0 : lanes;
			shift_pulse <= !is_latch;
			latch_pulse <= is_latch;
			layer_index <= 5'(layer_q);
			color_index <= is_latch ? COLOR_RED : color;
		end
	end

endmodule

/* src/led_cube_voxel_store_scanner.sv */
// Top level of the LED cube voxel store and layer scanner.
// Depends on lcvs_pkg, lcvs_ifs, lcvs_ctrl and lcvs_dpath.

// Serial bytes are accepted while the controller is idle and give no result; a scan tick
// does the registered read of all nine lane banks at the current row and column as it is
// accepted and then loads the result register, which then waits for the sink while the next
// beat can be accepted. A further tick holds in its load cycle until the sink has taken the
// earlier result. A clear command (0xE1 as a first byte) and reset both start a clearing pass
// over all 2048 addresses of the banks (one address per cycle, all lanes at once), during
// which no input beat is accepted.
module led_cube_voxel_store_scanner import lcvs_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	lcvs_in_if.sink     item_in,
	lcvs_out_if.source  res_out
);

	lcvs_cmd_t cmd;
	lcvs_sts_t sts;

	lcvs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_in.valid),
		.in_func   (item_in.func),
		.in_ready  (item_in.ready),
		.out_valid (res_out.valid),
		.out_ready (res_out.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lcvs_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.rx_byte     (item_in.rx_byte),
		.lane_bits   (res_out.lane_bits),
		.shift_pulse (res_out.shift_pulse),
		.latch_pulse (res_out.latch_pulse),
		.layer_index (res_out.layer_index),
		.color_index (res_out.color_index)
	);

	a_result_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_out.valid) |-> $past(item_in.valid && item_in.ready && item_in.func, 2))
		else $error("result beat without a scan tick");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!res_out.valid || res_out.ready))
		else $error("result register loaded while its beat is still waiting");

	a_pulse_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid |-> (res_out.shift_pulse ^ res_out.latch_pulse))
		else $error("result must be exactly one of shift or latch");

	a_clear_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(item_in.valid && item_in.ready && !item_in.func && sts.clear_req) |=> !item_in.ready)
		else $error("input taken during clearing pass");

endmodule

/* dv/tb_led_cube_voxel_store_scanner.sv */
// Testbench for led_cube_voxel_store_scanner: serial voxel writes, clears and scan ticks,
// checked beat by beat against a predictor of the store and scan sequence held in a class.
// Depends on lcvs_pkg, lcvs_ifs and the block's RTL.
`timescale 1ns / 100ps

module tb_led_cube_voxel_store_scanner;
	import lcvs_pkg::*;

	typedef struct packed {
		logic [8:0] lanes;
		logic       shift;
		logic       latch;
		logic [4:0] layer;
		logic [1:0] color;
	} scan_beat_t;

	typedef enum logic [1:0] {AWAIT_FIRST, HAVE_X, HAVE_Y} parse_t;

	class cube_scoreboard;
		logic [2:0] voxels [CUBE_SIDE][CUBE_SIDE][CUBE_LAYERS];
		parse_t     parse;
		logic [4:0] px, py;
		logic [1:0] red_green;
		int         step;
		int         layer;
		scan_beat_t pending [$];
		int         errors;

		function new();
			wipe_store();
			parse     = AWAIT_FIRST;
			px        = '0;
			py        = '0;
			red_green = '0;
			step      = 0;
			layer     = 0;
			errors    = 0;
		endfunction

		function void wipe_store();
			foreach (voxels[x, y, z])
				voxels[x][y][z] = '0;
		endfunction

		function void note_beat(input logic func, input logic [7:0] b);
			scan_beat_t e;
			int         slot, row, col, x, y;
			logic [4:0] z;
			logic [1:0] color;
			e = '0;
			if (!func) begin
				case (parse)
					HAVE_X: begin
						py           = b[4:0];
						red_green[1] = b[RGB_BIT];
						parse        = HAVE_Y;
					end
					HAVE_Y: begin
						z = b[4:0];
						if (px < CUBE_SIDE && py < CUBE_SIDE && z < CUBE_LAYERS)
							voxels[px][py][z] = {b[RGB_BIT], red_green};
						parse = AWAIT_FIRST;
					end
					default: begin
						if (b == CMD_CLEAR) begin
							wipe_store();
						end else if (b[START_BIT]) begin
							px        = b[4:0];
							red_green = {1'b0, b[RGB_BIT]};
							parse     = HAVE_X;
						end
					end
				endcase
				return;
			end
			if (step < int'(LATCH_STEP)) begin
				slot = step / (TILE_SIDE * TILE_SIDE);
				row  = (step / TILE_SIDE) % TILE_SIDE;
				col  = step % TILE_SIDE;
				case (slot)
					0: color = COLOR_GREEN;
					1: color = COLOR_BLUE;
					default: color = COLOR_RED;
				endcase
				for (int l = 0; l < LANES; l++) begin
					x = col + TILE_SIDE * (l % 3);
					y = row + TILE_SIDE * (l / 3);
					if (x < CUBE_SIDE && y < CUBE_SIDE)
						e.lanes[l] = voxels[x][y][layer][color];
				end
				e.shift = 1'b1;
				e.layer = 5'(layer);
				e.color = color;
				step++;
			end else begin
				e.latch = 1'b1;
				e.layer = 5'(layer);
				step    = 0;
				layer   = (layer + 1) % CUBE_LAYERS;
			end
			pending.push_back(e);
		endfunction

		function void flag(input string what, input logic [8:0] want, input logic [8:0] got);
			errors++;
			$display("%0t %s: expected %0h got %0h", $time, what, want, got);
		endfunction

		function void check_beat(input scan_beat_t got);
			scan_beat_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t unexpected beat: expected none got %0h", $time, got);
				return;
			end
			want = pending.pop_front();
			if (got.lanes !== want.lanes) flag("lane_bits", want.lanes, got.lanes);
			if (got.shift !== want.shift) flag("shift_pulse", 9'(want.shift), 9'(got.shift));
			if (got.latch !== want.latch) flag("latch_pulse", 9'(want.latch), 9'(got.latch));
			if (got.layer !== want.layer) flag("layer_index", 9'(want.layer), 9'(got.layer));
			if (got.color !== want.color) flag("color_index", 9'(want.color), 9'(got.color));
		endfunction
	endclass

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	int   idle_pct  = 0;
	int   stall_pct = 0;

	cube_scoreboard sb = new();

	lcvs_in_if  item_if ();
	lcvs_out_if res_if ();

	led_cube_voxel_store_scanner dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_in (item_if),
		.res_out (res_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5ms;
		$display("FAIL");
		$finish;
	end

	always @(posedge clk) begin : res_sink
		scan_beat_t got;
		got = {res_if.lane_bits, res_if.shift_pulse, res_if.latch_pulse,
			res_if.layer_index, res_if.color_index};
		if (arst_n && res_if.valid && res_if.ready)
			sb.check_beat(got);
		res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	task automatic send_beat(input logic func, input logic [7:0] b);
		while ($urandom_range(0, 99) < idle_pct) begin
			item_if.valid <= 1'b0;
			@(posedge clk);
		end
		item_if.valid   <= 1'b1;
		item_if.func    <= func;
		item_if.rx_byte <= b;
		@(posedge clk);
		while (!item_if.ready)
			@(posedge clk);
		sb.note_beat(func, b);
	endtask

	task automatic send_tick();
		send_beat(1'b1, 8'($urandom));
	endtask

	// three-byte voxel write, now and then with scan ticks slipped between its bytes
	task automatic send_write(input logic [4:0] z);
		logic [4:0] x, y;
		x = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(CUBE_SIDE, 31))
			: 5'($urandom_range(0, CUBE_SIDE - 1));
		y = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(CUBE_SIDE, 31))
			: 5'($urandom_range(0, CUBE_SIDE - 1));
		send_beat(1'b0, {1'b1, 2'($urandom), x});
		if ($urandom_range(0, 99) < 15)
			repeat ($urandom_range(1, 3)) send_tick();
		send_beat(1'b0, {3'($urandom), y});
		if ($urandom_range(0, 99) < 15)
			repeat ($urandom_range(1, 3)) send_tick();
		send_beat(1'b0, {3'($urandom), z});
	endtask

	task automatic drain();
		item_if.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_random(input int items);
		int done, pick, n;
		logic [7:0] b;
		done = 0;
		while (done < items) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				n = $urandom_range(1, 12);
				repeat (n) send_tick();
				done += n;
			end else if (pick < 88) begin
				send_write(($urandom_range(0, 3) != 0) ? 5'(sb.layer) : 5'($urandom));
				done += 3;
			end else if (pick < 98) begin
				b = 8'($urandom);
				send_beat(1'b0, b);
				if (b[START_BIT])
					done++;
			end else begin
				send_beat(1'b0, CMD_CLEAR);
				done++;
			end
		end
	endtask

	initial begin
		item_if.valid   = 1'b0;
		item_if.func    = 1'b0;
		item_if.rx_byte = '0;
		res_if.ready    = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// all colours at the near corner, red and green at the far corner
		send_beat(1'b0, 8'hC0); send_beat(1'b0, 8'h40); send_beat(1'b0, 8'h40);
		send_beat(1'b0, 8'hD7); send_beat(1'b0, 8'h57); send_beat(1'b0, 8'h00);
		// dropped writes: x past the side, then y past the side
		send_beat(1'b0, 8'h98); send_beat(1'b0, 8'h05); send_beat(1'b0, 8'h00);
		send_beat(1'b0, 8'h81); send_beat(1'b0, 8'hFF); send_beat(1'b0, 8'hE0);
		// pending write held across ticks, clear code taken raw as the z byte
		send_beat(1'b0, 8'h82); send_tick();
		send_beat(1'b0, 8'h03); send_tick();
		send_beat(1'b0, CMD_CLEAR);
		// lone bytes, then a real clear
		send_beat(1'b0, 8'h7F); send_beat(1'b0, 8'h00);
		send_tick();
		send_beat(1'b0, CMD_CLEAR);
		send_tick();
		drain();

		idle_pct = 0;  stall_pct = 0;  run_random(125); drain();
		idle_pct = 87; stall_pct = 0;  run_random(125); drain();
		idle_pct = 0;  stall_pct = 87; run_random(125); drain();
		idle_pct = 37; stall_pct = 37; run_random(125); drain();

		repeat (16) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
